// ----- hw/rtl/lbr_pkg.sv -----
// ---------------------------------------------------------------------------
// lbr_pkg
// Shared constants and types for the bounded random generator: generator
// constants, operand widths, sequencer states and the divider request.
// ---------------------------------------------------------------------------
package lbr_pkg;

   localparam int STATE_W  = 48;               // generator state
   localparam int DRAW_W   = 31;               // bits per draw and bound/value width
   localparam int SLICE_W  = 16;               // multiplier a operand
   localparam int MULB_W   = 35;               // multiplier b operand
   localparam int PROD_W   = SLICE_W + MULB_W;
   localparam int ACC_W    = 64;
   localparam int K_W      = 2;
   localparam int CNT_W    = $clog2(DRAW_W);
   localparam int CHK_W    = DRAW_W + 1;

   localparam logic [MULB_W-1:0] LCG_MULT = 35'h5DEECE66D;
   localparam logic [3:0]        LCG_ADD  = 4'hB;

   // last slice index of each multiply pass
   localparam logic [K_W-1:0] LCG_LAST_K   = 2'd2;
   localparam logic [K_W-1:0] SCALE_LAST_K = 2'd1;

   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_RELOAD = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } seq_state_type;

   typedef struct packed {
      logic              start;
      logic [DRAW_W-1:0] dividend;
      logic [DRAW_W-1:0] divisor;
   } div_req_type;

endpackage

// ----- hw/rtl/lcg48_bounded_random.sv -----
// ---------------------------------------------------------------------------
// lcg48_bounded_random
// Bounded random integers from a 48-bit linear congruential generator,
// stepped on a shared slice multiplier, reduced by a shared remainder unit.
// ---------------------------------------------------------------------------
//   channel   dir   handshake              payload
//   req       in    req_valid/req_stall    req_command, req_bound
//   rsp       out   rsp_valid/rsp_stall    rsp_value
//   csr       in    csr_wr_en              csr_wr_data (seed)
//
// reload and zero bound: final step, then idle.
// power-of-two bound: the generator step on the 16-bit slice multiplier,
// then the scaling multiply, then the final step.
// other bounds: the generator step, then the one-bit-per-cycle remainder
// unit, then the final step; each rejected draw repeats the generator step
// and the remainder unit. req_stall is high from accept until the result beat
// is registered, so a stalled result beat holds the block in its final step.
// synchronous reset puts the state at seed zero scrambled.
// ---------------------------------------------------------------------------
module lcg48_bounded_random import lbr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [DRAW_W-1:0]  req_bound,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DRAW_W-1:0]  rsp_value,
   input  logic               csr_wr_en,
   input  logic [STATE_W-1:0] csr_wr_data
);

   seq_state_type      seq_ff, seq_in;
   logic [STATE_W-1:0] lcg_ff, lcg_in;
   logic [STATE_W-1:0] seed_ff, seed_in;
   logic [DRAW_W-1:0]  bound_ff, bound_in;
   logic [DRAW_W-1:0]  bits_ff, bits_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic               scale_ff, scale_in;
   logic               pow2_ff, pow2_in;
   logic [DRAW_W-1:0]  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DRAW_W-1:0]  rsp_value_ff, rsp_value_in;

   logic [SLICE_W-1:0] mul_a;
   logic [MULB_W-1:0]  mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic [ACC_W-1:0]   acc_sum;
   logic               last_k;
   div_req_type        div_req;
   logic               div_done;
   logic [DRAW_W-1:0]  div_rem;
   logic [CHK_W-1:0]   chk;
   logic               rsp_load;

   lbr_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   lbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_rem  (div_rem)
   );

   // operand slices for the current multiply pass
   always_comb begin
      mul_a = '0;
      if (scale_ff) begin
         case (k_ff)
            2'd0:    mul_a = bits_ff[15:0];
            2'd1:    mul_a = SLICE_W'(bits_ff[30:16]);
            default: mul_a = '0;
         endcase
      end else begin
         case (k_ff)
            2'd0:    mul_a = lcg_ff[15:0];
            2'd1:    mul_a = lcg_ff[31:16];
            2'd2:    mul_a = lcg_ff[47:32];
            default: mul_a = '0;
         endcase
      end
      mul_b = scale_ff ? MULB_W'(bound_ff) : LCG_MULT;
   end

   assign acc_sum   = acc_ff + (ACC_W'(mul_prod) << (6'(k_ff) * 6'(SLICE_W)));
   assign last_k    = scale_ff ? (k_ff == SCALE_LAST_K) : (k_ff == LCG_LAST_K);
   assign chk       = CHK_W'(bits_ff) - CHK_W'(div_rem) + CHK_W'(bound_ff) - CHK_W'(1);
   assign req_stall = (seq_ff != ST_IDLE);
   assign rsp_load  = (seq_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign seed_in   = csr_wr_en ? csr_wr_data : seed_ff;

   always_comb begin
      seq_in           = seq_ff;
      lcg_in           = lcg_ff;
      bound_in         = bound_ff;
      bits_in          = bits_ff;
      acc_in           = acc_ff;
      k_in             = k_ff;
      scale_in         = scale_ff;
      pow2_in          = pow2_ff;
      res_in           = res_ff;
      div_req.start    = 1'b0;
      div_req.dividend = acc_sum[47:17];
      div_req.divisor  = bound_ff;
      unique case (seq_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bound_in = req_bound;
               res_in   = '0;
               if (req_command == CMD_RELOAD) begin
                  lcg_in = seed_ff ^ STATE_W'(LCG_MULT);
                  seq_in = ST_FIN;
               end else if (req_bound == '0) begin
                  seq_in = ST_FIN;
               end else begin
                  pow2_in  = ((req_bound & (req_bound - 1'b1)) == '0);
                  scale_in = 1'b0;
                  acc_in   = ACC_W'(LCG_ADD);
                  k_in     = '0;
                  seq_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            seq_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_sum;
            if (!last_k) begin
               k_in   = k_ff + 1'b1;
               seq_in = ST_MUL;
            end else if (scale_ff) begin
               res_in = acc_sum[61:31];
               seq_in = ST_FIN;
            end else begin
               lcg_in  = acc_sum[STATE_W-1:0];
               bits_in = acc_sum[47:17];
               if (pow2_ff) begin
                  scale_in = 1'b1;
                  acc_in   = '0;
                  k_in     = '0;
                  seq_in   = ST_MUL;
               end else begin
                  div_req.start = 1'b1;
                  seq_in        = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (!chk[DRAW_W]) begin
                  res_in = div_rem;
                  seq_in = ST_FIN;
               end else begin
                  // rejected draw: step the generator again
                  acc_in   = ACC_W'(LCG_ADD);
                  k_in     = '0;
                  scale_in = 1'b0;
                  seq_in   = ST_MUL;
               end
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               seq_in = ST_IDLE;
            end
         end
         default: seq_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ST_IDLE;
         lcg_ff       <= STATE_W'(LCG_MULT);
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         lcg_ff       <= lcg_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff     <= bound_in;
      bits_ff      <= bits_in;
      acc_ff       <= acc_in;
      k_ff         <= k_in;
      scale_ff     <= scale_in;
      pow2_ff      <= pow2_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepted beat");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> seq_ff == ST_DIV)
      else $error("remainder done outside divide step");

   a_fin_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      seq_ff == ST_FIN && !rsp_valid_ff |=> rsp_valid_ff && seq_ff == ST_IDLE)
      else $error("finished result not moved to output register");
`endif

endmodule

// ----- hw/rtl/lbr_mul.sv -----
// ---------------------------------------------------------------------------
// lbr_mul
// Shared 16 x 35 bit multiplier with a registered product, used slice by
// slice for the generator step and for power-of-two scaling.
// ---------------------------------------------------------------------------
module lbr_mul import lbr_pkg::*; (
   input  logic               clock,
   input  logic [SLICE_W-1:0] mul_a,
   input  logic [MULB_W-1:0]  mul_b,
   output logic [PROD_W-1:0]  mul_prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ----- hw/rtl/lbr_div.sv -----
// ---------------------------------------------------------------------------
// lbr_div
// Radix-2 restoring remainder unit: one quotient bit per cycle, done
// pulses with the remainder valid.
// ---------------------------------------------------------------------------
module lbr_div import lbr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   output logic              div_done,
   output logic [DRAW_W-1:0] div_rem
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DRAW_W-1:0] rem_ff, rem_in;
   logic [DRAW_W-1:0] dvd_ff, dvd_in;
   logic [DRAW_W-1:0] dsr_ff, dsr_in;
   logic [CHK_W-1:0]  trial;
   logic [DRAW_W-1:0] rem_step;

   always_comb begin
      trial = {rem_ff, dvd_ff[DRAW_W-1]};
      if (trial >= {1'b0, dsr_ff}) begin
         rem_step = DRAW_W'(trial - {1'b0, dsr_ff});
      end else begin
         rem_step = trial[DRAW_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[DRAW_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DRAW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_done = done_ff;
   assign div_rem  = rem_ff;

endmodule
